FILE: rtl/core/rpm_pkg.sv
// Shared types and codes for the response pattern matcher.
// No dependencies; imported by every module in rtl/core.
package rpm_pkg;

   // action codes on the request tuser
   localparam logic [1:0] ACT_BYTE = 2'd0;
   localparam logic [1:0] ACT_TICK = 2'd1;
   localparam logic [1:0] ACT_ARM  = 2'd2;

   // event codes on the response tuser
   localparam logic [1:0] EV_MATCHED   = 2'd0;
   localparam logic [1:0] EV_TIMEOUT   = 2'd1;
   localparam logic [1:0] EV_LINE_BYTE = 2'd2;
   localparam logic [1:0] EV_LINE_END  = 2'd3;

   // register indexes
   localparam logic [2:0] REG_PATTERN0 = 3'd0;
   localparam logic [2:0] REG_PATTERN1 = 3'd1;
   localparam logic [2:0] REG_PATTERN2 = 3'd2;
   localparam logic [2:0] REG_PATTERN3 = 3'd3;
   localparam logic [2:0] REG_LENGTH   = 3'd4;
   localparam logic [2:0] REG_TIMEOUT  = 3'd5;

   localparam int          CSR_INDEX_W   = 3;
   localparam int          CSR_DATA_W    = 64;
   localparam int          WORD_BYTES    = 8;
   localparam logic [7:0]  CR_BYTE       = 8'h0D;
   localparam logic [5:0]  LENGTH_RESET  = 6'd3;
   localparam logic [15:0] TIMEOUT_RESET = 16'd2000;
   localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

   typedef struct packed {
      logic [5:0]  pattern_length;
      logic [15:0] timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] data_byte;
   } item_type;

   typedef struct packed {
      logic [1:0]  event_res;
      logic [7:0]  line_byte;
      logic [15:0] bytes_before;
   } result_type;

endpackage

FILE: rtl/core/rpm_csr.sv
// Configuration registers: pattern bytes, pattern length and timeout.
// Depends on rpm_pkg.
module rpm_csr #(
   parameter int MAX_PATTERN = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write,
   input  logic [rpm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [rpm_pkg::CSR_DATA_W-1:0]   csr_data,
   output logic [MAX_PATTERN-1:0][7:0]      pattern,
   output rpm_pkg::cfg_type                 cfg
);
   import rpm_pkg::*;

   logic [MAX_PATTERN-1:0][7:0] pattern_ff, pattern_in;
   cfg_type                     cfg_ff, cfg_in;

   always_comb begin
      pattern_in = pattern_ff;
      cfg_in     = cfg_ff;
      if (csr_write) begin
         // byte i lives in word i/8, lane i%8
         for (int i = 0; i < MAX_PATTERN; i++) begin
            if (csr_index == CSR_INDEX_W'(i / WORD_BYTES)) begin
               pattern_in[i] = csr_data[8*(i % WORD_BYTES) +: 8];
            end
         end
         case (csr_index)
            REG_LENGTH:  cfg_in.pattern_length = csr_data[5:0];
            REG_TIMEOUT: cfg_in.timeout_ticks  = csr_data[15:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff            <= '0;
         cfg_ff.pattern_length <= LENGTH_RESET;
         cfg_ff.timeout_ticks  <= TIMEOUT_RESET;
      end else begin
         pattern_ff <= pattern_in;
         cfg_ff     <= cfg_in;
      end
   end

   assign pattern = pattern_ff;
   assign cfg     = cfg_ff;

endmodule

FILE: rtl/core/rpm_match.sv
// Match state and per-beat decision logic: arm, tick, byte and pass-through.
// Depends on rpm_pkg.
module rpm_match #(
   parameter int MAX_PATTERN = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  rpm_pkg::item_type           item,
   input  logic [MAX_PATTERN-1:0][7:0] pattern,
   input  rpm_pkg::cfg_type            cfg,
   output logic                        res_valid,
   output rpm_pkg::result_type         res
);
   import rpm_pkg::*;

   localparam int POS_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int LEN_W = $clog2(MAX_PATTERN + 1);

   logic             waiting_ff, waiting_in;
   logic [POS_W-1:0] match_pos_ff, match_pos_in;
   logic [15:0]      silent_ff, silent_in;
   logic [15:0]      received_ff, received_in;

   logic [LEN_W-1:0] eff_len;
   logic [15:0]      limit;
   logic [15:0]      silent_inc;
   logic             saturated;
   logic [15:0]      received_inc;
   logic             hit_pos;
   logic             hit_first;
   logic [LEN_W-1:0] pos_ext;

   always_comb begin
      if (cfg.pattern_length == 6'd0) begin
         eff_len = LEN_W'(1);
      end else if (cfg.pattern_length > 6'(MAX_PATTERN)) begin
         eff_len = LEN_W'(MAX_PATTERN);
      end else begin
         eff_len = LEN_W'(cfg.pattern_length);
      end
   end

   assign limit        = (cfg.timeout_ticks == 16'd0) ? 16'd1 : cfg.timeout_ticks;
   assign silent_inc   = (silent_ff < COUNT_MAX) ? silent_ff + 16'd1 : silent_ff;
   assign saturated    = (received_ff == COUNT_MAX);
   assign received_inc = saturated ? received_ff : received_ff + 16'd1;
   assign hit_pos      = (item.data_byte == pattern[match_pos_ff]);
   assign hit_first    = (item.data_byte == pattern[0]);

   always_comb begin
      waiting_in   = waiting_ff;
      match_pos_in = match_pos_ff;
      silent_in    = silent_ff;
      received_in  = received_ff;
      res_valid    = 1'b0;
      res          = '0;
      pos_ext      = LEN_W'(match_pos_ff);
      if (!hit_pos) begin
         pos_ext = '0;
      end
      if (step) begin
         case (item.action)
            ACT_ARM: begin
               waiting_in   = 1'b1;
               match_pos_in = '0;
               silent_in    = '0;
               received_in  = '0;
            end
            ACT_TICK: begin
               if (waiting_ff) begin
                  silent_in = silent_inc;
                  if (silent_inc >= limit) begin
                     waiting_in    = 1'b0;
                     res_valid     = 1'b1;
                     res.event_res = EV_TIMEOUT;
                  end
               end
            end
            ACT_BYTE: begin
               if (waiting_ff) begin
                  silent_in   = '0;
                  received_in = received_inc;
                  if (!hit_pos && !hit_first) begin
                     match_pos_in = '0;
                  end else if (pos_ext < eff_len - LEN_W'(1)) begin
                     match_pos_in = POS_W'(pos_ext + LEN_W'(1));
                  end else begin
                     waiting_in    = 1'b0;
                     match_pos_in  = '0;
                     res_valid     = 1'b1;
                     res.event_res = EV_MATCHED;
                     if (saturated) begin
                        res.bytes_before = COUNT_MAX;
                     end else if (received_inc >= 16'(eff_len)) begin
                        res.bytes_before = received_inc - 16'(eff_len);
                     end
                  end
               end else begin
                  res_valid = 1'b1;
                  if (item.data_byte == CR_BYTE) begin
                     res.event_res = EV_LINE_END;
                  end else begin
                     res.event_res = EV_LINE_BYTE;
                     res.line_byte = item.data_byte;
                  end
               end
            end
            default: begin
               res_valid = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         waiting_ff   <= 1'b0;
         match_pos_ff <= '0;
         silent_ff    <= '0;
         received_ff  <= '0;
      end else begin
         waiting_ff   <= waiting_in;
         match_pos_ff <= match_pos_in;
         silent_ff    <= silent_in;
         received_ff  <= received_in;
      end
   end

endmodule

FILE: rtl/core/response_pattern_matcher.sv
// Top level of the response pattern matcher: input register, match logic, result register.
// Depends on rpm_pkg, rpm_csr and rpm_match.

// Watches a received byte stream for an expected reply of 1 to MAX_PATTERN bytes.
// Each request beat carries an action in tuser (byte, timer tick or arm) and a byte in tdata.
// A beat is registered on entry and decided on its way into the result register, so the
// block takes one beat per clock unless a response is held; the only limit is the single
// pass through the pattern-byte compare and the counter update against the held match state.
// A response follows a match (with the count of bytes before the pattern, saturating at
// 65535), a timeout, and every byte seen while not armed; other beats give no response.
// Configuration writes are taken at any time and should be made while no beat is in flight.
module response_pattern_matcher #(
   parameter int MAX_PATTERN = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   // request: tdata = data_byte[7:0]; tuser = action[1:0]
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,
   input  logic [1:0]                      req_tuser,
   // response: tdata = line_byte[7:0], bytes_before[23:8]; tuser = event_res[1:0]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [23:0]                     rsp_tdata,
   output logic [1:0]                      rsp_tuser,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rpm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rpm_pkg::CSR_DATA_W-1:0]  csr_data
);
   import rpm_pkg::*;

   logic                        s1_valid_ff;
   item_type                    s1_item_ff;
   logic                        rsp_valid_ff;
   result_type                  rsp_ff;
   logic                        advance;
   logic                        res_valid;
   result_type                  res;
   logic [MAX_PATTERN-1:0][7:0] pattern;
   cfg_type                     cfg;

   assign csr_ready  = 1'b1;
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;

   rpm_csr #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .pattern   (pattern),
      .cfg       (cfg)
   );

   rpm_match #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_match (
      .clock     (clock),
      .reset     (reset),
      .step      (s1_valid_ff && advance),
      .item      (s1_item_ff),
      .pattern   (pattern),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res       (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= s1_valid_ff && res_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_item_ff.action    <= req_tuser;
         s1_item_ff.data_byte <= req_tdata;
      end
      if (advance && s1_valid_ff && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.event_res;
   assign rsp_tdata  = {rsp_ff.bytes_before, rsp_ff.line_byte};

   // the input stage only stalls behind a held response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s1_valid_ff && rsp_valid_ff && !rsp_tready)
      else $error("request stalled without a held response");

   // only pass-through beats carry a byte
   a_line_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.event_res != EV_LINE_BYTE |-> rsp_ff.line_byte == 8'd0)
      else $error("byte field set on a non line byte event");

   // only a match carries a byte count
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.event_res != EV_MATCHED |-> rsp_ff.bytes_before == 16'd0)
      else $error("byte count set on a non match event");

endmodule

FILE: test/response_pattern_matcher_tb.sv
// Self-checking testbench for response_pattern_matcher: directed table, then random waits.
// Depends on rpm_pkg and the RTL under rtl/core; a model predicts responses the table omits.
module response_pattern_matcher_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rpm_pkg::*;

   localparam int         MAX_PATTERN  = 32;
   localparam int         IDLE_LIMIT   = 2000;
   localparam int         DRAIN_CYCLES = 8;
   localparam int         PHASE_BEATS  = 125;
   localparam logic [1:0] ACT_UNUSED   = 2'd3;
   localparam logic [2:0] REG_SPARE    = 3'd7;
   localparam result_type NO_RESULT    = '0;

   typedef enum logic [1:0] {ROW_CSR, ROW_PREDICT, ROW_QUIET, ROW_GIVEN} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [2:0]   index;
      logic [63:0]  value;
      logic [1:0]   act;
      logic [7:0]   data;
      result_type   res;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [7:0]             req_tdata;
   logic [1:0]             req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [23:0]            rsp_tdata;
   logic [1:0]             rsp_tuser;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   response_pattern_matcher #(.MAX_PATTERN(MAX_PATTERN)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   // matcher model state and its copy of the registers
   logic [63:0] pat_words [4];
   logic [5:0]  pat_length;
   logic [15:0] timeout_limit;
   bit          match_waiting;
   int          match_pos;
   logic [15:0] silent_count;
   logic [15:0] byte_count;

   result_type  expected_events [$];
   result_type  want;
   int          mismatches = 0;
   int          beats_sent = 0;
   bit          calm_sender = 0;
   bit          hold_request = 0;

   function automatic logic [7:0] pattern_byte(input int i);
      logic [63:0] w;
      w = pat_words[(i >> 3) & 3];
      return w[(i & 7) * 8 +: 8];
   endfunction

   function automatic int active_length();
      int n;
      n = int'(pat_length);
      if (n == 0) n = 1;
      if (n > MAX_PATTERN) n = MAX_PATTERN;
      return n;
   endfunction

   function automatic int draw_gap();
      int r;
      r = $urandom_range(0, 19);
      if (r < 12) return 0;
      if (r < 18) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic stim_row_type csr_row(input logic [2:0] idx, input logic [63:0] val);
      stim_row_type r;
      r = '0;
      r.kind = ROW_CSR;
      r.index = idx;
      r.value = val;
      return r;
   endfunction

   function automatic stim_row_type beat_row(input row_kind_type k, input logic [1:0] a,
                                             input logic [7:0] d);
      stim_row_type r;
      r = '0;
      r.kind = k;
      r.act = a;
      r.data = d;
      return r;
   endfunction

   function automatic stim_row_type given_row(input logic [1:0] a, input logic [7:0] d,
                                              input logic [1:0] ev, input logic [7:0] lb,
                                              input logic [15:0] bb);
      stim_row_type r;
      r = beat_row(ROW_GIVEN, a, d);
      r.res.event_res = ev;
      r.res.line_byte = lb;
      r.res.bytes_before = bb;
      return r;
   endfunction

   task automatic apply_register_write(input logic [2:0] idx, input logic [63:0] val);
      case (idx)
         REG_PATTERN0: pat_words[0] = val;
         REG_PATTERN1: pat_words[1] = val;
         REG_PATTERN2: pat_words[2] = val;
         REG_PATTERN3: pat_words[3] = val;
         REG_LENGTH:   pat_length = val[5:0];
         REG_TIMEOUT:  timeout_limit = val[15:0];
         default: ;
      endcase
   endtask

   task automatic predict_event(input logic [1:0] act, input logic [7:0] b,
                                output bit produced, output result_type ev);
      int len;
      int pos;
      int limit;
      bit saturated;
      bit hit;
      produced = 0;
      ev = NO_RESULT;
      case (act)
         ACT_ARM: begin
            match_waiting = 1;
            match_pos = 0;
            silent_count = '0;
            byte_count = '0;
         end
         ACT_TICK: begin
            if (match_waiting) begin
               limit = (timeout_limit == 0) ? 1 : int'(timeout_limit);
               if (silent_count != COUNT_MAX) silent_count++;
               if (silent_count >= limit) begin
                  match_waiting = 0;
                  produced = 1;
                  ev.event_res = EV_TIMEOUT;
               end
            end
         end
         ACT_BYTE: begin
            if (match_waiting) begin
               len = active_length();
               saturated = (byte_count == COUNT_MAX);
               silent_count = '0;
               if (!saturated) byte_count++;
               pos = match_pos;
               hit = 1;
               // a mismatch restarts the match, and the byte gets one more try at position 0
               if (b != pattern_byte(pos)) begin
                  pos = 0;
                  if (b != pattern_byte(0)) hit = 0;
               end
               if (!hit) begin
                  match_pos = 0;
               end else if (pos < len - 1) begin
                  match_pos = pos + 1;
               end else begin
                  match_waiting = 0;
                  match_pos = 0;
                  produced = 1;
                  ev.event_res = EV_MATCHED;
                  if (saturated) ev.bytes_before = COUNT_MAX;
                  else ev.bytes_before = (byte_count >= len) ? 16'(byte_count - len) : 16'd0;
               end
            end else begin
               produced = 1;
               if (b == CR_BYTE) begin
                  ev.event_res = EV_LINE_END;
               end else begin
                  ev.event_res = EV_LINE_BYTE;
                  ev.line_byte = b;
               end
            end
         end
         default: ;
      endcase
   endtask

   // called at a falling edge, returns at a falling edge
   task automatic offer_beat(input row_kind_type kind, input logic [1:0] act,
                             input logic [7:0] b, input result_type given);
      int gap;
      bit produced;
      result_type ev;
      gap = calm_sender ? 0 : draw_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_event(act, b, produced, ev);
      case (kind)
         ROW_PREDICT: if (produced) expected_events.push_back(ev);
         ROW_GIVEN:   expected_events.push_back(given);
         default: ;
      endcase
      if (act != ACT_UNUSED) beats_sent++;
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_register_write(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // beats without a response may still be in flight, hence the drain
   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_events.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_events.size() == 0) begin
            $error("response beat with nothing expected: event_res %0d, tdata %h",
                   rsp_tuser, rsp_tdata);
            mismatches++;
         end else begin
            want = expected_events.pop_front();
            if (rsp_tuser !== want.event_res) begin
               $error("event_res: expected %0d, got %0d", want.event_res, rsp_tuser);
               mismatches++;
            end
            if (rsp_tdata[7:0] !== want.line_byte) begin
               $error("line_byte: expected %h, got %h", want.line_byte, rsp_tdata[7:0]);
               mismatches++;
            end
            if (rsp_tdata[23:8] !== want.bytes_before) begin
               $error("bytes_before: expected %0d, got %0d", want.bytes_before,
                      rsp_tdata[23:8]);
               mismatches++;
            end
         end
      end
   end

   // receiver: short and long stalls, runs of ready, one long hold on request
   initial begin : receiver
      int rx_hold;
      int rx_run;
      rx_hold = 0;
      rx_run = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (!reset) begin
            if (hold_request) begin
               hold_request = 0;
               rx_hold = 400;
            end
            if (rx_hold == 0 && rx_run == 0) begin
               rx_hold = draw_gap();
               rx_run = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 20);
            end
            if (rx_hold > 0) begin
               rsp_tready <= 1'b0;
               rx_hold--;
            end else begin
               rsp_tready <= 1'b1;
               rx_run--;
            end
         end
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle = 0;
         else
            idle++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin : stimulus
      stim_row_type directed [$];
      int           p;
      int           k;
      int           steps;
      int           cap;
      int           target;
      bit           clean;
      logic [63:0]  w;
      logic [5:0]   len_val;
      logic [15:0]  limit_val;

      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = ACT_BYTE;
      csr_valid = 1'b0;
      csr_index = REG_PATTERN0;
      csr_data = '0;
      for (int i = 0; i < 4; i++) pat_words[i] = '0;
      pat_length = LENGTH_RESET;
      timeout_limit = TIMEOUT_RESET;
      match_waiting = 0;
      match_pos = 0;
      silent_count = '0;
      byte_count = '0;

      // reset pattern is three zero bytes, length 3
      directed.push_back(given_row(ACT_BYTE, 8'h41, EV_LINE_BYTE, 8'h41, 16'd0));
      directed.push_back(given_row(ACT_BYTE, CR_BYTE, EV_LINE_END, 8'h00, 16'd0));
      directed.push_back(given_row(ACT_BYTE, 8'h00, EV_LINE_BYTE, 8'h00, 16'd0));
      directed.push_back(given_row(ACT_BYTE, 8'hFF, EV_LINE_BYTE, 8'hFF, 16'd0));
      directed.push_back(beat_row(ROW_QUIET, ACT_TICK, 8'h00));
      directed.push_back(beat_row(ROW_QUIET, ACT_UNUSED, 8'hAA));
      directed.push_back(beat_row(ROW_QUIET, ACT_ARM, 8'h5A));
      directed.push_back(beat_row(ROW_QUIET, ACT_BYTE, 8'h00));
      directed.push_back(beat_row(ROW_QUIET, ACT_BYTE, 8'h00));
      directed.push_back(given_row(ACT_BYTE, 8'h00, EV_MATCHED, 8'h00, 16'd0));
      directed.push_back(beat_row(ROW_QUIET, ACT_ARM, 8'h00));
      directed.push_back(beat_row(ROW_QUIET, ACT_BYTE, 8'h55));
      // re-arm mid-wait clears the byte count
      directed.push_back(beat_row(ROW_QUIET, ACT_ARM, 8'h00));
      directed.push_back(beat_row(ROW_QUIET, ACT_BYTE, 8'h00));
      directed.push_back(beat_row(ROW_QUIET, ACT_BYTE, 8'h00));
      directed.push_back(given_row(ACT_BYTE, 8'h00, EV_MATCHED, 8'h00, 16'd0));
      // "OK\r"; zero length acts as one, zero timeout acts as one tick
      directed.push_back(csr_row(REG_PATTERN0, 64'h0000_0000_000D_4B4F));
      directed.push_back(csr_row(REG_LENGTH, 64'd0));
      directed.push_back(csr_row(REG_TIMEOUT, 64'd0));
      directed.push_back(beat_row(ROW_QUIET, ACT_ARM, 8'h00));
      directed.push_back(given_row(ACT_BYTE, 8'h4F, EV_MATCHED, 8'h00, 16'd0));
      directed.push_back(beat_row(ROW_QUIET, ACT_ARM, 8'h00));
      directed.push_back(given_row(ACT_TICK, 8'h00, EV_TIMEOUT, 8'h00, 16'd0));
      directed.push_back(csr_row(REG_LENGTH, 64'd3));
      directed.push_back(csr_row(REG_TIMEOUT, 64'd2000));
      // O O K CR: second O restarts onto pattern byte 0
      directed.push_back(beat_row(ROW_QUIET, ACT_ARM, 8'h00));
      directed.push_back(beat_row(ROW_PREDICT, ACT_BYTE, 8'h4F));
      directed.push_back(beat_row(ROW_PREDICT, ACT_BYTE, 8'h4F));
      directed.push_back(beat_row(ROW_PREDICT, ACT_BYTE, 8'h4B));
      directed.push_back(beat_row(ROW_PREDICT, ACT_BYTE, CR_BYTE));

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed[i]) begin
         if (directed[i].kind == ROW_CSR) begin
            settle();
            write_reg(directed[i].index, directed[i].value);
         end else begin
            offer_beat(directed[i].kind, directed[i].act, directed[i].data, directed[i].res);
         end
      end

      // not waiting now, so every byte gives a beat while the receiver holds off
      hold_request = 1;
      repeat (40) offer_beat(ROW_PREDICT, ACT_BYTE, 8'($urandom), NO_RESULT);

      for (p = 0; p < 8; p++) begin
         settle();
         case (p)
            0: begin len_val = 6'd32; limit_val = 16'hFFFF; end
            1: begin len_val = 6'd1;  limit_val = 16'd1; end
            2: begin len_val = 6'd0;  limit_val = 16'd0; end
            3: begin
               len_val = 6'($urandom_range(33, 63));
               limit_val = 16'($urandom_range(1, 20));
            end
            default: begin
               len_val = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(7, 32))
                                                     : 6'($urandom_range(1, 6));
               limit_val = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(100, 3000))
                                                       : 16'($urandom_range(1, 24));
            end
         endcase
         for (int r = 0; r < 4; r++) write_reg(3'(REG_PATTERN0 + r), {$urandom, $urandom});
         w = {$urandom, $urandom};
         w[5:0] = len_val;
         write_reg(REG_LENGTH, w);
         w = {$urandom, $urandom};
         w[15:0] = limit_val;
         write_reg(REG_TIMEOUT, w);
         if (p == 3) write_reg(REG_SPARE, {$urandom, $urandom});
         calm_sender = ($urandom_range(0, 3) == 0);

         target = beats_sent + PHASE_BEATS;
         while (beats_sent < target) begin
            k = $urandom_range(0, 9);
            if (k < 7) begin
               clean = (k < 4);
               offer_beat(ROW_PREDICT, ACT_ARM, 8'($urandom), NO_RESULT);
               if (clean)
                  repeat ($urandom_range(0, 3))
                     offer_beat(ROW_PREDICT, ACT_BYTE, 8'($urandom), NO_RESULT);
               cap = 3 * active_length() + 10;
               steps = 0;
               while (match_waiting && steps < cap) begin
                  k = $urandom_range(0, 99);
                  if (clean ? (k < 90) : (k < 40))
                     offer_beat(ROW_PREDICT, ACT_BYTE, pattern_byte(match_pos), NO_RESULT);
                  else if (clean || (k >= 80 && k < 95))
                     offer_beat(ROW_PREDICT, ACT_TICK, 8'($urandom), NO_RESULT);
                  else if (k < 60)
                     offer_beat(ROW_PREDICT, ACT_BYTE, pattern_byte(0), NO_RESULT);
                  else if (k < 80)
                     offer_beat(ROW_PREDICT, ACT_BYTE, 8'($urandom), NO_RESULT);
                  else
                     offer_beat(ROW_PREDICT, ACT_UNUSED, 8'($urandom), NO_RESULT);
                  steps++;
               end
            end
            // line traffic and loose noise between waits
            repeat ($urandom_range(0, 4)) begin
               k = $urandom_range(0, 9);
               if (k < 2)
                  offer_beat(ROW_PREDICT, ACT_BYTE, CR_BYTE, NO_RESULT);
               else if (k < 8)
                  offer_beat(ROW_PREDICT, ACT_BYTE, 8'($urandom), NO_RESULT);
               else
                  offer_beat(ROW_PREDICT, 2'($urandom_range(0, 3)), 8'($urandom), NO_RESULT);
            end
         end
      end

      settle();
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
